FILE: rtl/core/r76c_pkg.sv
// ----------------------------------------------------------------------------
// r76c_pkg
// Shared types and constants of the radix-76 byte/text codec.
// ----------------------------------------------------------------------------
package r76c_pkg;

   // Default geometry
   localparam int ALPHABET_SIZE  = 76;
   localparam int TOKEN_BUFFER   = 64;

   // Character code space of the symbol alphabet (7-bit symbols)
   localparam int CHAR_CODES     = 128;

   // Result queue: at most three results per transaction
   localparam int MAX_PUSH       = 3;
   localparam int PUSH_CW        = $clog2(MAX_PUSH + 1);
   localparam int RSP_FIFO_DEPTH = 8;

   // Opcodes of an input transaction
   localparam logic [1:0] OP_DATA  = 2'd0;
   localparam logic [1:0] OP_END   = 2'd1;
   localparam logic [1:0] OP_ALPHA = 2'd2;

   // Error codes of a result
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG = 2'd3;

   // Characters
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] MAX_BYTE     = 8'hFF;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data_byte;
      logic [6:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] error_code;
      logic       last;
   } rsp_type;

endpackage

FILE: rtl/core/r76c_rsp_fifo.sv
// ----------------------------------------------------------------------------
// r76c_rsp_fifo
// Result queue: takes up to three results per cycle, gives one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module r76c_rsp_fifo #(
   parameter int DEPTH = r76c_pkg::RSP_FIFO_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [r76c_pkg::PUSH_CW-1:0]    push_cnt,
   input  r76c_pkg::rsp_type               push_data [r76c_pkg::MAX_PUSH],
   output logic [$clog2(DEPTH+1)-1:0]      count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output r76c_pkg::rsp_type               rsp_payload
);

   localparam int PW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int PCW = r76c_pkg::PUSH_CW;

   r76c_pkg::rsp_type fifo_mem [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [PW-1:0]     wr_pos [r76c_pkg::MAX_PUSH+1];
   logic              pop;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = fifo_mem[rd_ptr_ff];
   assign count       = count_ff;

   // Slot positions for the results pushed this cycle
   always_comb begin
      wr_pos[0] = wr_ptr_ff;
      for (int j = 1; j <= r76c_pkg::MAX_PUSH; j++) begin
         wr_pos[j] = ptr_inc(wr_pos[j-1]);
      end
   end

   always_comb begin
      wr_ptr_in = wr_pos[push_cnt];
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push_cnt) - CW'(pop);
   end

   // Store pushed results
   always_ff @(posedge clock) begin
      for (int j = 0; j < r76c_pkg::MAX_PUSH; j++) begin
         if (PCW'(j) < push_cnt) begin
            fifo_mem[wr_pos[j]] <= push_data[j];
         end
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (int'(count_ff) + int'(push_cnt) <= DEPTH))
      else $error("result queue overflow");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (count_ff == '0))
      else $error("result queue not empty after reset");

   a_idle_stable: assert property (@(posedge clock) disable iff (reset)
      (!pop && push_cnt == '0) |=> $stable(count_ff) && $stable(rd_ptr_ff))
      else $error("result queue moved without a push or pop");

endmodule

FILE: rtl/core/radix76_byte_text_codec_top.sv
// ----------------------------------------------------------------------------
// radix76_byte_text_codec_top
// Radix-76 byte/text codec over a loadable 7-bit symbol alphabet.
//
// Usage:
//  - req_* carries one transaction per handshake: a data byte, an end of
//    stream, or an alphabet entry write. rsp_* returns results one per
//    handshake; last marks the final result of a transaction.
//  - csr_write_en/csr_write_data set the direction (0 encode, 1 decode);
//    write it only while the block is idle.
//  - A transaction is registered in the second stage, then its results
//    in the result queue. A decode transaction is taken every cycle while
//    req_ready is high; an encode byte gives up to three results (space and
//    two symbols), and the single result port drains one per cycle.
//  - An alphabet write rebuilds the inverse map by sweeping the alphabet
//    memory read port, one entry per cycle; req_ready stays low through
//    the sweep and the drain state after it.
//  - Reset clears the control state, the direction and the inverse map
//    (all characters invalid); the alphabet itself is undefined until loaded.
//  - When rsp_ready is low, results collect in an 8-entry queue; req_ready
//    drops once the queue cannot take the results of one more transaction.
// ----------------------------------------------------------------------------
module radix76_byte_text_codec_top #(
   parameter int ALPHABET_SIZE = r76c_pkg::ALPHABET_SIZE,
   parameter int TOKEN_BUFFER  = r76c_pkg::TOKEN_BUFFER
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  r76c_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output r76c_pkg::rsp_type rsp_payload,
   input  logic              csr_write_en,
   input  logic              csr_write_data
);

   localparam int AW      = $clog2(ALPHABET_SIZE);
   localparam int LW      = $clog2(TOKEN_BUFFER);
   localparam int VW      = $clog2(256 * ALPHABET_SIZE);
   localparam int MAX_Q   = 255 / ALPHABET_SIZE;
   localparam int DEPTH   = r76c_pkg::RSP_FIFO_DEPTH;
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int PCW     = r76c_pkg::PUSH_CW;
   localparam int NCHAR   = r76c_pkg::CHAR_CODES;
   localparam logic [7:0] SIZE_B = 8'(ALPHABET_SIZE);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN
   } sweep_state_type;

   // Configuration
   logic direction_ff;

   // Memories and their read data
   logic [6:0]    alphabet_mem [ALPHABET_SIZE];
   logic [AW-1:0] inverse_mem  [NCHAR];
   logic [6:0]    alpha_rd0_ff;
   logic [6:0]    alpha_rd1_ff;
   logic [AW-1:0] inv_rd_ff;
   logic          inv_hit_ff;
   logic [NCHAR-1:0] inv_valid_ff;

   // Rebuild sweep
   sweep_state_type state_ff;
   logic [AW-1:0]   sweep_idx_ff;
   logic            sweep_wr_en_ff;
   logic [AW-1:0]   sweep_wr_idx_ff;

   // Second stage
   logic       s2_valid_ff;
   logic [1:0] s2_op_ff;
   logic [7:0] s2_char_ff;

   // Token state
   logic          first_token_ff, first_token_in;
   logic [7:0]    token_value_ff, token_value_in;
   logic          value_overflow_ff, value_overflow_in;
   logic          bad_symbol_ff, bad_symbol_in;
   logic [LW-1:0] token_length_ff, token_length_in;
   logic          halted_ff, halted_in;

   // Front end
   logic          req_fire;
   logic          alpha_wr;
   logic [AW-1:0] enc_hi;
   logic [7:0]    enc_base;
   logic [AW-1:0] enc_lo;
   logic [AW-1:0] rd_addr0;
   logic          room;

   // Result path
   logic [CW-1:0]     fifo_count;
   logic [PCW-1:0]    push_cnt;
   r76c_pkg::rsp_type push_data [r76c_pkg::MAX_PUSH];
   r76c_pkg::rsp_type fin_rsp;
   logic              fin_halt;
   logic [VW-1:0]     acc;
   logic              is_white;

   // Accept when idle and the queue can take a full set of results
   assign room = s2_valid_ff ? (fifo_count <= CW'(DEPTH - 2 * r76c_pkg::MAX_PUSH))
                             : (fifo_count <= CW'(DEPTH - r76c_pkg::MAX_PUSH));
   assign req_ready = (state_ff == ST_IDLE) && room;
   assign req_fire  = req_valid && req_ready;
   assign alpha_wr  = req_fire && (req_payload.opcode == r76c_pkg::OP_ALPHA) &&
                      ({1'b0, req_payload.entry_index} < SIZE_B);

   // Split the byte into high and low digits by compare against multiples
   always_comb begin
      enc_hi   = '0;
      enc_base = '0;
      for (int k = 1; k <= MAX_Q; k++) begin
         if (req_payload.data_byte >= 8'(k * ALPHABET_SIZE)) begin
            enc_hi   = AW'(k);
            enc_base = 8'(k * ALPHABET_SIZE);
         end
      end
      enc_lo = AW'(req_payload.data_byte - enc_base);
   end

   assign rd_addr0 = (state_ff == ST_SWEEP) ? sweep_idx_ff : enc_lo;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
      end else if (csr_write_en) begin
         direction_ff <= csr_write_data;
      end
   end

   // Alphabet memory: one write port, two read ports
   always_ff @(posedge clock) begin
      if (alpha_wr) begin
         alphabet_mem[req_payload.entry_index[AW-1:0]] <= req_payload.data_byte[6:0];
      end
      alpha_rd0_ff <= alphabet_mem[rd_addr0];
      alpha_rd1_ff <= alphabet_mem[enc_hi];
   end

   // Inverse map memory: sweep writes, decode reads
   always_ff @(posedge clock) begin
      if (sweep_wr_en_ff) begin
         inverse_mem[alpha_rd0_ff] <= sweep_wr_idx_ff;
      end
      inv_rd_ff <= inverse_mem[req_payload.data_byte[6:0]];
   end

   // Inverse map valid bits and decode hit
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_valid_ff <= '0;
      end else if (alpha_wr) begin
         inv_valid_ff <= '0;
      end else if (sweep_wr_en_ff) begin
         inv_valid_ff[alpha_rd0_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      inv_hit_ff <= inv_valid_ff[req_payload.data_byte[6:0]] &&
                    !req_payload.data_byte[7] && (req_payload.data_byte != 8'd0);
   end

   // Rebuild sweep: walk the alphabet from the top so the lowest position wins
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sweep_idx_ff    <= '0;
         sweep_wr_en_ff  <= 1'b0;
         sweep_wr_idx_ff <= '0;
      end else begin
         sweep_wr_en_ff  <= (state_ff == ST_SWEEP);
         sweep_wr_idx_ff <= sweep_idx_ff;
         unique case (state_ff)
            ST_IDLE: begin
               if (alpha_wr) begin
                  state_ff     <= ST_SWEEP;
                  sweep_idx_ff <= AW'(ALPHABET_SIZE - 1);
               end
            end
            ST_SWEEP: begin
               sweep_idx_ff <= sweep_idx_ff - 1'b1;
               if (sweep_idx_ff == '0) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Second stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      s2_op_ff   <= req_payload.opcode;
      s2_char_ff <= req_payload.data_byte;
   end

   // Result of a completed token
   always_comb begin
      fin_rsp  = '0;
      fin_halt = bad_symbol_ff || value_overflow_ff;
      if (bad_symbol_ff) begin
         fin_rsp.error_code = r76c_pkg::ERR_BAD_CHAR;
      end else if (value_overflow_ff) begin
         fin_rsp.error_code = r76c_pkg::ERR_OVERFLOW;
      end else begin
         fin_rsp.out_byte   = token_value_ff;
         fin_rsp.error_code = r76c_pkg::ERR_NONE;
      end
   end

   assign acc = VW'(token_value_ff) * VW'(ALPHABET_SIZE) + VW'(inv_rd_ff);
   assign is_white = (s2_char_ff == r76c_pkg::CHAR_SPACE) ||
                     ((s2_char_ff >= r76c_pkg::CHAR_TAB) && (s2_char_ff <= r76c_pkg::CHAR_CR));

   // Process one transaction: update token state and build results
   always_comb begin
      push_data         = '{default: '0};
      push_cnt          = '0;
      first_token_in    = first_token_ff;
      token_value_in    = token_value_ff;
      value_overflow_in = value_overflow_ff;
      bad_symbol_in     = bad_symbol_ff;
      token_length_in   = token_length_ff;
      halted_in         = halted_ff;
      if (s2_valid_ff) begin
         unique case (s2_op_ff)
            r76c_pkg::OP_END: begin
               if (!direction_ff) begin
                  push_data[0].out_byte = r76c_pkg::CHAR_NEWLINE;
                  push_cnt              = PCW'(1);
               end else if (!halted_ff && token_length_ff != '0) begin
                  push_data[0] = fin_rsp;
                  push_cnt     = PCW'(1);
               end
               first_token_in    = 1'b1;
               halted_in         = 1'b0;
               token_value_in    = '0;
               value_overflow_in = 1'b0;
               bad_symbol_in     = 1'b0;
               token_length_in   = '0;
            end
            r76c_pkg::OP_DATA: begin
               if (!halted_ff) begin
                  if (!direction_ff) begin
                     // Encode: optional separator, then digits high first
                     first_token_in = 1'b0;
                     if (!first_token_ff) begin
                        push_data[push_cnt].out_byte = r76c_pkg::CHAR_SPACE;
                        push_cnt = push_cnt + 1'b1;
                     end
                     if (s2_char_ff >= SIZE_B) begin
                        push_data[push_cnt].out_byte = {1'b0, alpha_rd1_ff};
                        push_cnt = push_cnt + 1'b1;
                     end
                     push_data[push_cnt].out_byte = {1'b0, alpha_rd0_ff};
                     push_cnt = push_cnt + 1'b1;
                  end else if (is_white) begin
                     // Decode: whitespace closes a pending token
                     if (token_length_ff != '0) begin
                        push_data[0]      = fin_rsp;
                        push_cnt          = PCW'(1);
                        halted_in         = fin_halt;
                        token_value_in    = '0;
                        value_overflow_in = 1'b0;
                        bad_symbol_in     = 1'b0;
                        token_length_in   = '0;
                     end
                  end else if (token_length_ff >= LW'(TOKEN_BUFFER - 1)) begin
                     push_data[0].error_code = r76c_pkg::ERR_TOO_LONG;
                     push_cnt                = PCW'(1);
                     halted_in               = 1'b1;
                     token_value_in          = '0;
                     value_overflow_in       = 1'b0;
                     bad_symbol_in           = 1'b0;
                     token_length_in         = '0;
                  end else begin
                     // Accumulate one digit; hold the value once it overflows
                     token_length_in = token_length_ff + 1'b1;
                     if (!inv_hit_ff) begin
                        bad_symbol_in = 1'b1;
                     end else if (!value_overflow_ff) begin
                        if (acc > VW'(r76c_pkg::MAX_BYTE)) begin
                           value_overflow_in = 1'b1;
                        end else begin
                           token_value_in = acc[7:0];
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (push_cnt != '0) begin
         push_data[push_cnt - 1'b1].last = 1'b1;
      end
   end

   // Token state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_token_ff    <= 1'b1;
         token_value_ff    <= '0;
         value_overflow_ff <= 1'b0;
         bad_symbol_ff     <= 1'b0;
         token_length_ff   <= '0;
         halted_ff         <= 1'b0;
      end else begin
         first_token_ff    <= first_token_in;
         token_value_ff    <= token_value_in;
         value_overflow_ff <= value_overflow_in;
         bad_symbol_ff     <= bad_symbol_in;
         token_length_ff   <= token_length_in;
         halted_ff         <= halted_in;
      end
   end

   r76c_rsp_fifo #(
      .DEPTH(DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_data  (push_data),
      .count      (fifo_count),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   a_sweep_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("transaction taken during inverse map rebuild");

   a_alpha_write_sweeps: assert property (@(posedge clock) disable iff (reset)
      alpha_wr |=> (state_ff == ST_SWEEP) && (sweep_idx_ff == AW'(ALPHABET_SIZE - 1)))
      else $error("alphabet write did not start a rebuild");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (int'(fifo_count) + r76c_pkg::MAX_PUSH <= DEPTH))
      else $error("no queue room for a transaction in flight");

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the radix-76 byte/text codec. A cycle-free model
// of the codec predicts the outputs of every accepted transaction; a
// response process compares each output with the oldest prediction. Directed
// tests cover byte and token extremes, error cases and alphabet corners, then
// random encode and decode phases run under random idling and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   localparam int         HALF_PERIOD     = 4;
   localparam logic       DIR_ENCODE      = 1'b0;
   localparam logic       DIR_DECODE      = 1'b1;
   localparam logic [1:0] OP_UNUSED       = 2'd3;
   localparam logic [7:0] NO_DIGIT        = 8'hFF;
   localparam logic [7:0] BASE_CHAR       = 8'h21;
   localparam int         MAX_REPORTS     = 10;
   localparam int         STALL_LIMIT     = 3000;
   localparam int         RSP_HOLD_CYCLES = 300;
   localparam int         RANDOM_ITEMS    = 230;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   r76c_pkg::req_type req_payload    = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   r76c_pkg::rsp_type rsp_payload;
   logic              csr_write_en   = 1'b0;
   logic              csr_write_data = 1'b0;

   // Codec model state
   logic              mode;
   logic [6:0]        symbol_of [r76c_pkg::ALPHABET_SIZE];
   logic [7:0]        digit_of  [r76c_pkg::CHAR_CODES];
   logic              at_stream_start;
   int unsigned       acc_value;
   logic              acc_overflow;
   logic              acc_bad_char;
   int                acc_length;
   logic              muted;
   r76c_pkg::rsp_type step_outputs[$];
   r76c_pkg::rsp_type awaited_outputs[$];

   // Run control and bookkeeping
   logic steady      = 1'b0;
   logic hold_rsp    = 1'b0;
   int   mismatch_count;
   int   traffic_items;
   int   alphabet_writes;
   int   outputs_checked;
   int   error_outputs;
   int   quiet_cycles;

   always #HALF_PERIOD clock = ~clock;

   radix76_byte_text_codec_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // ------------------------------------------------------------------------
   // Codec model
   // ------------------------------------------------------------------------
   function automatic r76c_pkg::rsp_type make_output(logic [7:0] value, logic [1:0] err);
      r76c_pkg::rsp_type r;
      r.out_byte   = value;
      r.error_code = err;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic logic is_separator(logic [7:0] ch);
      return ch == r76c_pkg::CHAR_SPACE ||
             (ch >= r76c_pkg::CHAR_TAB && ch <= r76c_pkg::CHAR_CR);
   endfunction

   function automatic void clear_token();
      acc_value    = 0;
      acc_overflow = 1'b0;
      acc_bad_char = 1'b0;
      acc_length   = 0;
   endfunction

   // Each character maps to its lowest alphabet position; NUL never maps
   function automatic void rebuild_digit_map();
      foreach (digit_of[i]) digit_of[i] = NO_DIGIT;
      for (int i = r76c_pkg::ALPHABET_SIZE - 1; i >= 0; i--)
         digit_of[symbol_of[i]] = 8'(i);
      digit_of[0] = NO_DIGIT;
   endfunction

   // Close the open token: its byte, or its error (which mutes the stream)
   function automatic void close_token();
      if (acc_bad_char) begin
         step_outputs.push_back(make_output(8'h00, r76c_pkg::ERR_BAD_CHAR));
         muted = 1'b1;
      end else if (acc_overflow) begin
         step_outputs.push_back(make_output(8'h00, r76c_pkg::ERR_OVERFLOW));
         muted = 1'b1;
      end else begin
         step_outputs.push_back(make_output(8'(acc_value), r76c_pkg::ERR_NONE));
      end
      clear_token();
   endfunction

   // Work out the outputs of one accepted transaction and queue them
   function automatic void compute_codec_outputs(r76c_pkg::req_type item);
      logic [7:0]        ch;
      int unsigned       digit;
      r76c_pkg::rsp_type tail;
      ch = item.data_byte;
      step_outputs.delete();
      case (item.opcode)
         r76c_pkg::OP_ALPHA: begin
            if (item.entry_index < r76c_pkg::ALPHABET_SIZE) begin
               symbol_of[item.entry_index] = ch[6:0];
               rebuild_digit_map();
            end
         end
         r76c_pkg::OP_END: begin
            if (mode == DIR_ENCODE)
               step_outputs.push_back(make_output(r76c_pkg::CHAR_NEWLINE,
                                                  r76c_pkg::ERR_NONE));
            else if (!muted && acc_length > 0)
               close_token();
            at_stream_start = 1'b1;
            muted           = 1'b0;
            clear_token();
         end
         r76c_pkg::OP_DATA: begin
            if (!muted) begin
               if (mode == DIR_ENCODE) begin
                  if (!at_stream_start)
                     step_outputs.push_back(make_output(r76c_pkg::CHAR_SPACE,
                                                        r76c_pkg::ERR_NONE));
                  at_stream_start = 1'b0;
                  if (ch >= r76c_pkg::ALPHABET_SIZE)
                     step_outputs.push_back(make_output(
                        {1'b0, symbol_of[(ch / r76c_pkg::ALPHABET_SIZE) %
                                         r76c_pkg::ALPHABET_SIZE]},
                        r76c_pkg::ERR_NONE));
                  step_outputs.push_back(make_output(
                     {1'b0, symbol_of[ch % r76c_pkg::ALPHABET_SIZE]}, r76c_pkg::ERR_NONE));
               end else if (is_separator(ch)) begin
                  if (acc_length > 0) close_token();
               end else if (acc_length >= r76c_pkg::TOKEN_BUFFER - 1) begin
                  step_outputs.push_back(make_output(8'h00, r76c_pkg::ERR_TOO_LONG));
                  muted = 1'b1;
                  clear_token();
               end else begin
                  digit = ch[7] ? NO_DIGIT : digit_of[ch[6:0]];
                  acc_length++;
                  if (digit >= r76c_pkg::ALPHABET_SIZE)
                     acc_bad_char = 1'b1;
                  else if (!acc_overflow) begin
                     if (acc_value * r76c_pkg::ALPHABET_SIZE + digit > r76c_pkg::MAX_BYTE)
                        acc_overflow = 1'b1;
                     else
                        acc_value = acc_value * r76c_pkg::ALPHABET_SIZE + digit;
                  end
               end
            end
         end
         default: ;
      endcase
      // Mark the final output of this transaction
      if (step_outputs.size() > 0) begin
         tail = step_outputs.pop_back();
         tail.last = 1'b1;
         step_outputs.push_back(tail);
      end
      foreach (step_outputs[i]) awaited_outputs.push_back(step_outputs[i]);
   endfunction

   // Character that currently stands for a digit
   function automatic logic [7:0] digit_char(int unsigned digit);
      return {1'b0, symbol_of[digit % r76c_pkg::ALPHABET_SIZE]};
   endfunction

   function automatic logic [7:0] pick_separator();
      if ($urandom_range(0, 5) == 0) return r76c_pkg::CHAR_SPACE;
      return r76c_pkg::CHAR_TAB + 8'($urandom_range(0, 4));
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                            input logic [6:0] idx);
      r76c_pkg::req_type item;
      item.opcode      = op;
      item.data_byte   = ch;
      item.entry_index = idx;
      // Idle now and then, never inside a steady stretch
      if (!steady && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      compute_codec_outputs(item);
      if (op == r76c_pkg::OP_DATA || op == r76c_pkg::OP_END) traffic_items++;
      if (op == r76c_pkg::OP_ALPHA) alphabet_writes++;
   endtask

   task automatic send_data(input logic [7:0] ch);
      send_item(r76c_pkg::OP_DATA, ch, 7'($urandom));
   endtask

   task automatic send_end();
      send_item(r76c_pkg::OP_END, 8'($urandom), 7'($urandom));
   endtask

   // Send a value as base-76 digits, most significant first
   task automatic send_number(input int unsigned value, input int digits);
      int unsigned scale;
      scale = 1;
      for (int i = 1; i < digits; i++) scale *= r76c_pkg::ALPHABET_SIZE;
      for (int i = 0; i < digits; i++) begin
         send_data(digit_char((value / scale) % r76c_pkg::ALPHABET_SIZE));
         scale /= r76c_pkg::ALPHABET_SIZE;
      end
   endtask

   // Stop offering and wait until the codec has nothing left to give
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_outputs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic set_direction(input logic dir);
      drain_results();
      csr_write_en   <= 1'b1;
      csr_write_data <= dir;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      mode = dir;
   endtask

   // ------------------------------------------------------------------------
   // Response side: drive ready, check every accepted output
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input r76c_pkg::rsp_type want,
                                  input r76c_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected byte %02h err %0d last %0b, got byte %02h err %0d last %0b",
                  $time, what, want.out_byte, want.error_code, want.last,
                  got.out_byte, got.error_code, got.last);
   endtask

   initial begin : rsp_side
      int                hold_left;
      r76c_pkg::rsp_type want;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            outputs_checked++;
            if (awaited_outputs.size() == 0) begin
               report_mismatch("unexpected output", '0, rsp_payload);
            end else begin
               want = awaited_outputs.pop_front();
               if (want.error_code != r76c_pkg::ERR_NONE) error_outputs++;
               if (rsp_payload.out_byte !== want.out_byte ||
                   rsp_payload.error_code !== want.error_code ||
                   rsp_payload.last !== want.last)
                  report_mismatch("output mismatch", want, rsp_payload);
            end
         end
         // Long hold-off on request, otherwise random idling
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
            if (hold_left == 0) hold_rsp = 1'b0;
         end else if (hold_rsp) begin
            hold_left = RSP_HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= 25);
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic load_alphabet();
      for (int i = 0; i < r76c_pkg::ALPHABET_SIZE; i++)
         send_item(r76c_pkg::OP_ALPHA, BASE_CHAR + 8'(i), 7'(i));
   endtask

   task automatic test_encode_extremes();
      send_data(8'd0);      // one symbol, no leading space
      send_data(8'd75);
      send_data(8'd76);     // first two-symbol byte
      send_data(8'd151);
      send_data(8'd152);
      send_data(r76c_pkg::MAX_BYTE);
      send_end();
   endtask

   task automatic test_decode_tokens();
      set_direction(DIR_DECODE);
      send_number(0, 1);
      send_data(r76c_pkg::CHAR_SPACE);
      send_number(r76c_pkg::MAX_BYTE, 2);
      send_data(r76c_pkg::CHAR_TAB);
      send_number(75, 1);
      send_data(r76c_pkg::CHAR_NEWLINE);
      send_data(r76c_pkg::CHAR_CR);           // separators back to back
      send_number(7, 3);                      // leading zero digits
      send_data(r76c_pkg::CHAR_TAB + 8'd2);
      send_number(200, 2);
      send_end();                             // flushes the open token
      send_end();                             // nothing open
   endtask

   task automatic test_decode_errors();
      send_number(256, 2);          // one above the byte range
      send_data(r76c_pkg::CHAR_SPACE);
      send_number(5, 1);            // muted until end of stream
      send_data(r76c_pkg::CHAR_SPACE);
      send_end();
      send_number(300, 2);
      send_data(8'hA1);             // bad character beats the overflow
      send_data(r76c_pkg::CHAR_CR - 8'd1);
      send_end();
      send_data(8'h00);             // NUL is never a digit
      send_end();
   endtask

   task automatic test_alphabet_corners();
      send_item(r76c_pkg::OP_ALPHA, 8'h7A, 7'd127);   // index out of range: dropped
      send_data(8'h7A);
      send_end();
      send_item(r76c_pkg::OP_ALPHA, r76c_pkg::CHAR_SPACE, 7'd75);
      send_item(r76c_pkg::OP_ALPHA, 8'h00, 7'd74);
      send_item(r76c_pkg::OP_ALPHA, 8'hA1, 7'd73);    // top bit dropped: duplicates entry 0
      send_data(digit_char(73));
      send_data(r76c_pkg::CHAR_SPACE);                // space separates even as a symbol
      send_data(digit_char(2));
      send_end();
      set_direction(DIR_ENCODE);
      send_data(8'd73);
      send_data(8'd74);
      send_data(8'd75);
      send_end();
      for (int i = 73; i < r76c_pkg::ALPHABET_SIZE; i++)
         send_item(r76c_pkg::OP_ALPHA, BASE_CHAR + 8'(i), 7'(i));
   endtask

   task automatic test_direction_midstream();
      send_data(8'd10);
      set_direction(DIR_DECODE);
      send_number(9, 1);                     // token left open
      set_direction(DIR_ENCODE);
      send_data(8'd200);                     // stream already started: space first
      send_end();
      set_direction(DIR_DECODE);
      send_data(8'h00);
      send_data(r76c_pkg::CHAR_SPACE);       // error mutes the stream
      set_direction(DIR_ENCODE);
      set_direction(DIR_ENCODE);
      send_data(8'd1);                       // still muted
      send_end();
   endtask

   task automatic test_backpressure();
      set_direction(DIR_ENCODE);
      hold_rsp = 1'b1;
      repeat (24) send_data(8'($urandom_range(r76c_pkg::ALPHABET_SIZE, 255)));
      while (hold_rsp) @(posedge clock);
      drain_results();
   endtask

   task automatic random_encode_step();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85)      send_data(8'($urandom));
      else if (roll < 92) send_end();
      else if (roll < 96) send_item(r76c_pkg::OP_ALPHA, 8'($urandom), 7'($urandom));
      else                send_item(OP_UNUSED, 8'($urandom), 7'($urandom));
   endtask

   task automatic random_decode_token();
      int          roll;
      int unsigned value;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         value = $urandom_range(0, 255);
         send_number(value, (value < r76c_pkg::ALPHABET_SIZE ? 1 : 2) +
                            ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0));
      end else if (roll < 75) begin
         send_number($urandom_range(0, r76c_pkg::ALPHABET_SIZE ** 3 - 1),
                     $urandom_range(1, 3));
      end else if (roll < 85) begin
         repeat ($urandom_range(1, 4)) send_data(8'($urandom));
      end else if (roll < 88) begin
         // Zero-valued tokens around the length limit
         repeat ($urandom_range(r76c_pkg::TOKEN_BUFFER - 2, r76c_pkg::TOKEN_BUFFER + 2))
            send_data(digit_char(0));
      end else if (roll < 95) begin
         send_end();
         return;
      end else begin
         send_item(OP_UNUSED, 8'($urandom), 7'($urandom));
      end
      if ($urandom_range(0, 9) == 0) send_end();
      else send_data(pick_separator());
   endtask

   task automatic test_random_traffic();
      int first_item;
      int phase_end;
      first_item = traffic_items;
      while (traffic_items - first_item < RANDOM_ITEMS) begin
         steady = 1'b0;
         set_direction(1'($urandom_range(0, 1)));
         phase_end = traffic_items + $urandom_range(20, 60);
         while (traffic_items < phase_end) begin
            steady = (traffic_items - first_item >= 80 && traffic_items - first_item < 190);
            if (mode == DIR_ENCODE) random_encode_step();
            else random_decode_token();
         end
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      mode = DIR_ENCODE;
      foreach (symbol_of[i]) symbol_of[i] = '0;
      foreach (digit_of[i]) digit_of[i] = NO_DIGIT;
      at_stream_start = 1'b1;
      muted           = 1'b0;
      clear_token();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      load_alphabet();
      test_encode_extremes();
      test_decode_tokens();
      test_decode_errors();
      test_alphabet_corners();
      test_direction_midstream();
      test_backpressure();
      test_random_traffic();

      drain_results();
      repeat (20) @(posedge clock);
      if (awaited_outputs.size() != 0) begin
         $display("%0d predicted outputs never arrived", awaited_outputs.size());
         mismatch_count += awaited_outputs.size();
      end

      $display("run: %0d data/end transactions, %0d alphabet writes, %0d outputs checked",
               traffic_items, alphabet_writes, outputs_checked);
      $display("run: %0d error outputs, %0d mismatches", error_outputs, mismatch_count);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
